// File: sv/cau_pkg.sv
// Shared types, constants and saturation helpers for the complex arithmetic unit.
`timescale 1ns / 1ps
package cau_pkg;

  localparam int FRAC_BITS = 16;
  localparam int WORD_BITS = 32;
  localparam int PORT_BITS = 32;
  localparam int CMD_BITS  = 3;
  localparam int PROD_BITS = 2 * WORD_BITS;
  localparam int SUM_BITS  = PROD_BITS + 1;
  localparam int X_BITS    = PROD_BITS + FRAC_BITS;
  localparam int CMP_BITS  = PROD_BITS + FRAC_BITS + WORD_BITS;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_ADD = 3'd0,
    CMD_SUB = 3'd1,
    CMD_MUL = 3'd2,
    CMD_DIV = 3'd3,
    CMD_MAG = 3'd4
  } cmd_t;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic signed [WORD_BITS:0]   ext_t;
  typedef logic signed [PROD_BITS-1:0] prod_t;
  typedef logic signed [SUM_BITS-1:0]  sum_t;
  typedef logic [PROD_BITS-1:0]        mag_t;
  typedef logic [WORD_BITS-1:0]        quo_t;
  typedef logic [X_BITS-1:0]           x_t;
  typedef logic [CMP_BITS-1:0]         cmp_t;

  localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  typedef struct packed {
    cmd_t  cmd;
    word_t ar;
    word_t ai;
    word_t br;
    word_t bi;
  } op_t;

  typedef struct packed {
    word_t val;
    logic  ovf;
  } sat_t;

  typedef struct packed {
    logic neg;
    logic big;
    mag_t rem;
    quo_t quo;
    quo_t low;
  } lane_t;

  typedef struct packed {
    logic  vld;
    cmd_t  cmd;
    word_t re;
    word_t im;
    logic  ovf;
    logic  dz;
    mag_t  den;
    lane_t lre;
    lane_t lim;
  } stage_t;

  function automatic sat_t sat_sum(input sum_t v);
    sat_t r;
    if (v > sum_t'(WORD_MAX)) begin
      r.val = WORD_MAX;
      r.ovf = 1'b1;
    end else if (v < sum_t'(WORD_MIN)) begin
      r.val = WORD_MIN;
      r.ovf = 1'b1;
    end else begin
      r.val = v[WORD_BITS-1:0];
      r.ovf = 1'b0;
    end
    return r;
  endfunction

  function automatic sat_t quo_word(input logic neg, input logic big, input quo_t q);
    sat_t r;
    if (neg) begin
      if (big || q > quo_t'(WORD_MIN)) begin
        r.val = WORD_MIN;
        r.ovf = 1'b1;
      end else begin
        r.val = word_t'(0) - word_t'(q);
        r.ovf = 1'b0;
      end
    end else begin
      if (big || q > quo_t'(WORD_MAX)) begin
        r.val = WORD_MAX;
        r.ovf = 1'b1;
      end else begin
        r.val = word_t'(q);
        r.ovf = 1'b0;
      end
    end
    return r;
  endfunction

endpackage

// File: sv/cau_in_if.sv
// Operand channel: command and two complex operands with valid/ready.
`timescale 1ns / 1ps
interface cau_in_if import cau_pkg::*;;
  logic                        valid;
  logic                        ready;
  logic [CMD_BITS-1:0]         command;
  logic signed [PORT_BITS-1:0] a_re;
  logic signed [PORT_BITS-1:0] a_im;
  logic signed [PORT_BITS-1:0] b_re;
  logic signed [PORT_BITS-1:0] b_im;

  modport source (output valid, command, a_re, a_im, b_re, b_im, input ready);
  modport sink (input valid, command, a_re, a_im, b_re, b_im, output ready);
endinterface

// File: sv/cau_out_if.sv
// Result channel: complex result and status flags with valid/ready.
`timescale 1ns / 1ps
interface cau_out_if import cau_pkg::*;;
  logic                        valid;
  logic                        ready;
  logic signed [PORT_BITS-1:0] res_re;
  logic signed [PORT_BITS-1:0] res_im;
  logic                        overflowed;
  logic                        divide_by_zero;

  modport source (output valid, res_re, res_im, overflowed, divide_by_zero, input ready);
  modport sink (input valid, res_re, res_im, overflowed, divide_by_zero, output ready);
endinterface

// File: sv/complex_arithmetic_unit.sv
// Complex arithmetic unit top level: front pipeline, divider chain and output register.
//
// Usage: drive in_ch with a command (add, subtract, multiply, divide, squared
// magnitude of a) and two complex Q16.16 operands; collect one result per item
// on out_ch with saturation and divide-by-zero flags.
// A transfer happens on each channel when valid and ready are both high.
// Throughput: one item per cycle while out_ch is not stalled.
// Path from input transfer to out_ch.valid: four front stages (operand register,
// multipliers, product sums, saturation and divider setup), one restoring-division
// stage per quotient bit, and the output register. All commands take the same path,
// so results leave in input order.
// Stall: when out_ch.valid is high and out_ch.ready is low, every stage holds
// and in_ch.ready drops in the same cycle; nothing is lost or repeated.
// Reset: synchronous, active low; clears all stage valid bits, so out_ch.valid
// is low after reset. No configuration and no kept state between items.
`timescale 1ns / 1ps
module complex_arithmetic_unit import cau_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  cau_in_if.sink   in_ch,
  cau_out_if.source out_ch
);

  logic   en;
  op_t    op;
  stage_t pipe [0:WORD_BITS];
  stage_t last;
  sat_t   q_re, q_im;

  logic   out_vld_r;
  word_t  res_re_r, res_im_r;
  logic   ovf_r, dz_r;
  word_t  res_re_nxt, res_im_nxt;
  logic   ovf_nxt, dz_nxt;

  assign en          = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en;

  always_comb begin
    op.cmd = cmd_t'(in_ch.command);
    op.ar  = word_t'(in_ch.a_re[WORD_BITS-1:0]);
    op.ai  = word_t'(in_ch.a_im[WORD_BITS-1:0]);
    op.br  = word_t'(in_ch.b_re[WORD_BITS-1:0]);
    op.bi  = word_t'(in_ch.b_im[WORD_BITS-1:0]);
  end

  cau_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_vld (in_ch.valid),
    .op_i   (op),
    .st_o   (pipe[0])
  );

  for (genvar i = 0; i < WORD_BITS; i++) begin : g_div
    cau_div_stage u_div (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .st_i  (pipe[i]),
      .st_o  (pipe[i+1])
    );
  end

  assign last = pipe[WORD_BITS];

  always_comb begin
    q_re = quo_word(last.lre.neg, last.lre.big, last.lre.quo);
    q_im = quo_word(last.lim.neg, last.lim.big, last.lim.quo);
    dz_nxt = last.dz;
    if (last.cmd == CMD_DIV && !last.dz) begin
      res_re_nxt = q_re.val;
      res_im_nxt = q_im.val;
      ovf_nxt    = q_re.ovf | q_im.ovf;
    end else begin
      res_re_nxt = last.re;
      res_im_nxt = last.im;
      ovf_nxt    = last.ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= last.vld;
    end
    if (en) begin
      res_re_r <= res_re_nxt;
      res_im_r <= res_im_nxt;
      ovf_r    <= ovf_nxt;
      dz_r     <= dz_nxt;
    end
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.res_re         = PORT_BITS'(res_re_r);
  assign out_ch.res_im         = PORT_BITS'(res_im_r);
  assign out_ch.overflowed     = ovf_r;
  assign out_ch.divide_by_zero = dz_r;

`ifndef SYNTH
  a_dz_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && dz_r |-> res_re_r == WORD_MAX && res_im_r == WORD_MAX && !ovf_r)
    else $error("divide by zero result not saturated");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(last.vld) && $stable(out_vld_r) && $stable(res_re_r))
    else $error("pipeline moved during stall");
`endif

endmodule

// File: sv/cau_front.sv
// Front pipeline: operand register, multipliers, product sums, saturation and divider setup.
`timescale 1ns / 1ps
module cau_front import cau_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   en,
  input  logic   in_vld,
  input  op_t    op_i,
  output stage_t st_o
);

  logic   v1_r;
  op_t    op1_r;

  logic   v2_r;
  cmd_t   cmd2_r;
  prod_t  m_r [0:5];
  prod_t  m_nxt [0:5];
  ext_t   s_re2_r, s_im2_r;
  ext_t   s_re2_nxt, s_im2_nxt;
  word_t  y0, y1;

  logic   v3_r;
  cmd_t   cmd3_r;
  sum_t   rs3_r, is3_r;
  sum_t   rs3_nxt, is3_nxt;
  mag_t   den3_r;
  ext_t   s_re3_r, s_im3_r;

  stage_t st_r;
  stage_t st_nxt;
  sum_t   rsh, ish;
  sat_t   sa_re, sa_im, sm_re, sm_im;

  function automatic lane_t lane_init(input sum_t v, input mag_t den);
    lane_t l;
    sum_t  a;
    x_t    x;
    l.neg = v[SUM_BITS-1];
    a     = l.neg ? -v : v;
    x     = x_t'(a[PROD_BITS-1:0]) << FRAC_BITS;
    l.big = (cmp_t'(a[PROD_BITS-1:0]) << FRAC_BITS) >= (cmp_t'(den) << WORD_BITS);
    l.rem = mag_t'(x >> WORD_BITS);
    l.low = x[WORD_BITS-1:0];
    l.quo = '0;
    return l;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_vld;
    end
    if (en) begin
      op1_r <= op_i;
    end
  end

  always_comb begin
    y0 = (op1_r.cmd == CMD_MAG) ? op1_r.ar : op1_r.br;
    y1 = (op1_r.cmd == CMD_MAG) ? op1_r.ai : op1_r.bi;
    m_nxt[0] = prod_t'(op1_r.ar) * prod_t'(y0);
    m_nxt[1] = prod_t'(op1_r.ai) * prod_t'(y1);
    m_nxt[2] = prod_t'(op1_r.ar) * prod_t'(op1_r.bi);
    m_nxt[3] = prod_t'(op1_r.ai) * prod_t'(op1_r.br);
    m_nxt[4] = prod_t'(op1_r.br) * prod_t'(op1_r.br);
    m_nxt[5] = prod_t'(op1_r.bi) * prod_t'(op1_r.bi);
    if (op1_r.cmd == CMD_SUB) begin
      s_re2_nxt = ext_t'(op1_r.ar) - ext_t'(op1_r.br);
      s_im2_nxt = ext_t'(op1_r.ai) - ext_t'(op1_r.bi);
    end else begin
      s_re2_nxt = ext_t'(op1_r.ar) + ext_t'(op1_r.br);
      s_im2_nxt = ext_t'(op1_r.ai) + ext_t'(op1_r.bi);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
    if (en) begin
      cmd2_r  <= op1_r.cmd;
      m_r     <= m_nxt;
      s_re2_r <= s_re2_nxt;
      s_im2_r <= s_im2_nxt;
    end
  end

  always_comb begin
    if (cmd2_r == CMD_MUL) begin
      rs3_nxt = sum_t'(m_r[0]) - sum_t'(m_r[1]);
    end else begin
      rs3_nxt = sum_t'(m_r[0]) + sum_t'(m_r[1]);
    end
    if (cmd2_r == CMD_DIV) begin
      is3_nxt = sum_t'(m_r[3]) - sum_t'(m_r[2]);
    end else begin
      is3_nxt = sum_t'(m_r[2]) + sum_t'(m_r[3]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
    if (en) begin
      cmd3_r  <= cmd2_r;
      rs3_r   <= rs3_nxt;
      is3_r   <= is3_nxt;
      den3_r  <= mag_t'(m_r[4]) + mag_t'(m_r[5]);
      s_re3_r <= s_re2_r;
      s_im3_r <= s_im2_r;
    end
  end

  always_comb begin
    rsh   = rs3_r >>> FRAC_BITS;
    ish   = is3_r >>> FRAC_BITS;
    sa_re = sat_sum(sum_t'(s_re3_r));
    sa_im = sat_sum(sum_t'(s_im3_r));
    sm_re = sat_sum(rsh);
    sm_im = sat_sum(ish);
    st_nxt.vld = v3_r;
    st_nxt.cmd = cmd3_r;
    st_nxt.den = den3_r;
    st_nxt.lre = lane_init(rs3_r, den3_r);
    st_nxt.lim = lane_init(is3_r, den3_r);
    st_nxt.re  = '0;
    st_nxt.im  = '0;
    st_nxt.ovf = 1'b0;
    st_nxt.dz  = 1'b0;
    case (cmd3_r)
      CMD_ADD, CMD_SUB: begin
        st_nxt.re  = sa_re.val;
        st_nxt.im  = sa_im.val;
        st_nxt.ovf = sa_re.ovf | sa_im.ovf;
      end
      CMD_MUL: begin
        st_nxt.re  = sm_re.val;
        st_nxt.im  = sm_im.val;
        st_nxt.ovf = sm_re.ovf | sm_im.ovf;
      end
      CMD_MAG: begin
        st_nxt.re  = sm_re.val;
        st_nxt.ovf = sm_re.ovf;
      end
      CMD_DIV: begin
        st_nxt.dz = (den3_r == '0);
        st_nxt.re = WORD_MAX;
        st_nxt.im = WORD_MAX;
      end
      default: begin
        st_nxt.re = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.vld <= 1'b0;
    end else if (en) begin
      st_r <= st_nxt;
    end
  end

  assign st_o = st_r;

endmodule

// File: sv/cau_div_stage.sv
// One restoring-division stage: one quotient bit per lane, registered.
`timescale 1ns / 1ps
module cau_div_stage import cau_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   en,
  input  stage_t st_i,
  output stage_t st_o
);

  stage_t st_r;
  stage_t st_nxt;

  function automatic lane_t div_step(input lane_t l, input mag_t den);
    lane_t             r;
    logic [PROD_BITS:0] r2;
    r  = l;
    r2 = {l.rem, l.low[WORD_BITS-1]};
    if (r2 >= {1'b0, den}) begin
      r2    = r2 - {1'b0, den};
      r.quo = {l.quo[WORD_BITS-2:0], 1'b1};
    end else begin
      r.quo = {l.quo[WORD_BITS-2:0], 1'b0};
    end
    r.rem = r2[PROD_BITS-1:0];
    r.low = l.low << 1;
    return r;
  endfunction

  always_comb begin
    st_nxt     = st_i;
    st_nxt.lre = div_step(st_i.lre, st_i.den);
    st_nxt.lim = div_step(st_i.lim, st_i.den);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.vld <= 1'b0;
    end else if (en) begin
      st_r <= st_nxt;
    end
  end

  assign st_o = st_r;

endmodule

// File: sim/tb.sv
// Self-checking testbench for the complex arithmetic unit: directed and random operands.
`timescale 1ns / 1ps
module tb import cau_pkg::*;;

  typedef struct {
    logic [31:0] re;
    logic [31:0] im;
    logic        ovf;
    logic        dz;
  } cres_t;

  class cau_scoreboard;
    cres_t pending[$];
    int    n_bad;
    int    n_ok;

    static function automatic void sat_signed(input longint v, inout logic ovf,
                                              output logic [31:0] w);
      if (v > 64'sd2147483647) begin
        ovf = 1'b1;
        w = 32'h7fffffff;
      end else if (v < -64'sd2147483648) begin
        ovf = 1'b1;
        w = 32'h80000000;
      end else begin
        w = v[31:0];
      end
    endfunction

    static function automatic void mag_word(input logic neg, input logic [127:0] m,
                                            inout logic ovf, output logic [31:0] w);
      if (neg) begin
        if (m > 128'h80000000) begin
          ovf = 1'b1;
          w = 32'h80000000;
        end else begin
          w = 32'd0 - m[31:0];
        end
      end else if (m > 128'h7fffffff) begin
        ovf = 1'b1;
        w = 32'h7fffffff;
      end else begin
        w = m[31:0];
      end
    endfunction

    // product sum arrives as 128-bit two's complement
    static function automatic void shift_floor(input logic signed [127:0] s, inout logic ovf,
                                               output logic [31:0] w);
      logic signed [127:0] q;
      logic neg;
      q = s >>> FRAC_BITS;
      neg = q < 0;
      mag_word(neg, neg ? -q : q, ovf, w);
    endfunction

    static function automatic void quot(input logic signed [127:0] n, input logic [127:0] d,
                                        inout logic ovf, output logic [31:0] w);
      logic [127:0] m;
      logic [127:0] q;
      m = (n < 0) ? -n : n;
      q = (m << FRAC_BITS) / d;
      mag_word(n < 0 && q != 0, q, ovf, w);
    endfunction

    function automatic void note_operands(input logic [2:0] c, input logic signed [31:0] ar,
                                          input logic signed [31:0] ai,
                                          input logic signed [31:0] br,
                                          input logic signed [31:0] bi);
      cres_t r;
      logic signed [127:0] xr, xi, yr, yi, den;
      xr = ar; xi = ai; yr = br; yi = bi;
      r.re = '0; r.im = '0; r.ovf = 1'b0; r.dz = 1'b0;
      case (c)
        CMD_ADD: begin
          sat_signed(longint'(ar) + longint'(br), r.ovf, r.re);
          sat_signed(longint'(ai) + longint'(bi), r.ovf, r.im);
        end
        CMD_SUB: begin
          sat_signed(longint'(ar) - longint'(br), r.ovf, r.re);
          sat_signed(longint'(ai) - longint'(bi), r.ovf, r.im);
        end
        CMD_MUL: begin
          shift_floor(xr * yr - xi * yi, r.ovf, r.re);
          shift_floor(xr * yi + xi * yr, r.ovf, r.im);
        end
        CMD_DIV: begin
          den = yr * yr + yi * yi;
          if (den == 0) begin
            r.dz = 1'b1;
            r.re = 32'h7fffffff;
            r.im = 32'h7fffffff;
          end else begin
            quot(xr * yr + xi * yi, den, r.ovf, r.re);
            quot(xi * yr - xr * yi, den, r.ovf, r.im);
          end
        end
        CMD_MAG: shift_floor(xr * xr + xi * xi, r.ovf, r.re);
        default: ;
      endcase
      pending.push_back(r);
    endfunction

    function automatic void check_result(input cres_t got);
      cres_t e;
      if (pending.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected result re=%h im=%h", got.re, got.im);
        return;
      end
      e = pending.pop_front();
      if (got.re !== e.re || got.im !== e.im || got.ovf !== e.ovf || got.dz !== e.dz) begin
        n_bad++;
        if (n_bad <= 10)
          $display("mismatch: exp re=%h im=%h ovf=%b dz=%b got re=%h im=%h ovf=%b dz=%b",
                   e.re, e.im, e.ovf, e.dz, got.re, got.im, got.ovf, got.dz);
      end else begin
        n_ok++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  cau_in_if  in_ch();
  cau_out_if out_ch();
  cau_scoreboard board = new();

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_off = 1'b0;
  int hold_len = 0;
  longint cycles = 0;

  complex_arithmetic_unit dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("timeout");
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      board.check_result('{out_ch.res_re, out_ch.res_im, out_ch.overflowed,
                           out_ch.divide_by_zero});
  end

  // receiver ready, with a long hold-off on request
  always @(negedge clk) begin
    if (hold_len > 0) begin
      out_ch.ready <= 1'b0;
      hold_len <= hold_len - 1;
    end else if (hold_off) begin
      hold_len <= 300;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(7))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'd0;
      3: return $urandom_range(65536 * 4) - 131072;
      4: return {{8{$urandom_range(1) == 1}}, 24'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(input logic [2:0] c, input logic [31:0] ar, input logic [31:0] ai,
                           input logic [31:0] br, input logic [31:0] bi);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= c;
    in_ch.a_re <= ar; in_ch.a_im <= ai; in_ch.b_re <= br; in_ch.b_im <= bi;
    do @(posedge clk); while (!in_ch.ready);
    board.note_operands(c, ar, ai, br, bi);
    @(negedge clk);
  endtask

  task automatic pause_send();
    in_ch.valid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
  endtask

  task automatic random_items(input int n);
    logic [2:0] c;
    for (int i = 0; i < n; i++) begin
      c = ($urandom_range(15) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(4));
      if (c == CMD_DIV && $urandom_range(9) == 0)
        send_item(c, rand_word(), rand_word(), 32'd0, 32'd0);
      else
        send_item(c, rand_word(), rand_word(), rand_word(), rand_word());
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.command = '0;
    in_ch.a_re = '0; in_ch.a_im = '0; in_ch.b_re = '0; in_ch.b_im = '0;
    out_ch.ready = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_item(CMD_ADD, 32'h7fffffff, 32'h80000000, 32'h00000001, 32'hffffffff);
    send_item(CMD_ADD, 32'h00010000, 32'hfffe0000, 32'h00018000, 32'h00000003);
    send_item(CMD_SUB, 32'h80000000, 32'h7fffffff, 32'h00000001, 32'hffffffff);
    send_item(CMD_SUB, 32'h00030000, 32'h00010000, 32'h00010000, 32'h00050000);
    send_item(CMD_MUL, 32'h00020000, 32'h00030000, 32'hffff0000, 32'h00008000);
    send_item(CMD_MUL, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
    send_item(CMD_MUL, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
    send_item(CMD_MUL, 32'hffffffff, 32'h00000000, 32'h00000001, 32'h00000000);
    send_item(CMD_DIV, 32'h00010000, 32'h00000000, 32'h00020000, 32'h00000000);
    send_item(CMD_DIV, 32'h00050000, 32'hfffd0000, 32'h00010000, 32'h00020000);
    send_item(CMD_DIV, 32'h7fffffff, 32'h80000000, 32'h00000001, 32'h00000000);
    send_item(CMD_DIV, 32'h80000000, 32'h00000000, 32'h80000000, 32'h80000000);
    send_item(CMD_DIV, 32'h00010000, 32'h00010000, 32'h00000000, 32'h00000000);
    send_item(CMD_DIV, 32'hffffffff, 32'h00000001, 32'h7fffffff, 32'h7fffffff);
    send_item(CMD_MAG, 32'h00030000, 32'h00040000, 32'h12345678, 32'h9abcdef0);
    send_item(CMD_MAG, 32'h80000000, 32'h80000000, 32'h0, 32'h0);
    send_item(CMD_MAG, 32'hffffffff, 32'h00000000, 32'h0, 32'h0);
    send_item(3'd5, 32'h11111111, 32'h22222222, 32'h33333333, 32'h44444444);
    send_item(3'd6, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
    send_item(3'd7, 32'h80000000, 32'h7fffffff, 32'h1, 32'h2);
    pause_send();

    send_idle_pct = 23; recv_idle_pct = 54;
    random_items(160);
    hold_off = 1'b1;
    wait (hold_len > 0);
    hold_off = 1'b0;
    random_items(60);
    pause_send();
    send_idle_pct = 54; recv_idle_pct = 23;
    random_items(140);
    send_idle_pct = 0; recv_idle_pct = 0;
    random_items(140);
    in_ch.valid <= 1'b0;

    while (board.pending.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    $display("covered all commands incl. unknown codes, saturation and zero divisors;");
    $display("%0d results matched, %0d failures", board.n_ok, board.n_bad);
    if (board.n_bad == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end
endmodule
